>>> src/tick_pwm_encoder_key_scanner_core_defines.svh
// Assertion macros shared by the checker files of the tick PWM encoder key scanner.
`ifndef TICK_PWM_ENCODER_KEY_SCANNER_CORE_DEFINES_SVH
`define TICK_PWM_ENCODER_KEY_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPEK_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpek check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPEK_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpek check failed");

`endif

>>> src/tpek_pkg.sv
// Shared types and constants of the tick PWM encoder key scanner.
package tpek_pkg;

  localparam int unsigned NUM_LEDS   = 3;
  localparam int unsigned NUM_TIMERS = 3;
  localparam int unsigned NUM_KEYS   = 3;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned VALUE_W    = 16;

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_LOAD_TIMER  = 2'd1,
    CMD_CLEAR_FLAGS = 2'd2,
    CMD_SET_DIAL    = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  // One request item.
  typedef struct packed {
    cmd_e                      command;
    logic                      enc_phase_a;
    logic                      enc_phase_b;
    logic                      key_one_pin;
    logic                      key_two_pin;
    logic                      key_dial_pin;
    logic [1:0]                timer_select;
    logic signed [VALUE_W-1:0] write_value;
    logic [2:0]                flag_clear_mask;
  } req_t;

  // One result item.
  typedef struct packed {
    logic                      led_red_on;
    logic                      led_green_on;
    logic                      led_blue_on;
    logic signed [VALUE_W-1:0] dial_count;
    logic signed [VALUE_W-1:0] timer_zero;
    logic signed [VALUE_W-1:0] timer_one;
    logic signed [VALUE_W-1:0] timer_two;
    logic                      key_one_flag;
    logic                      key_two_flag;
    logic                      key_dial_flag;
  } res_t;

  // Strobes from the time base for the request being processed.
  typedef struct packed {
    logic tick;
    logic ms;
    logic scan;
  } strb_t;

  // Dial, timer and flag state after the request.
  typedef struct packed {
    logic signed [VALUE_W-1:0] dial;
    logic signed [VALUE_W-1:0] timer0;
    logic signed [VALUE_W-1:0] timer1;
    logic signed [VALUE_W-1:0] timer2;
    logic [NUM_KEYS-1:0]       flags;
  } dk_state_t;

endpackage

>>> src/tpek_timebase.sv
// Tick counter and millisecond phase that produce the encoder and scan strobes.
module tpek_timebase import tpek_pkg::*; #(
  parameter int unsigned TICKS_PER_MS   = 10,
  parameter int unsigned TICKS_PER_SCAN = 100
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  tick_i,
  output strb_t strb_o
);

  localparam int unsigned TcW = $clog2(TICKS_PER_SCAN + 1);
  localparam int unsigned PhW = $clog2(TICKS_PER_MS + 1);

  logic [TcW-1:0] tick_q, tick_d, tick_base;
  logic [PhW-1:0] phase_q, phase_d, phase_base;
  logic           scan;

  // The phase tracks the tick count modulo the millisecond length.
  always_comb begin
    scan       = (tick_q >= TcW'(TICKS_PER_SCAN));
    tick_base  = scan ? '0 : tick_q;
    phase_base = scan ? '0 : phase_q;
    tick_d     = tick_base + TcW'(1);
    if (phase_base == PhW'(TICKS_PER_MS - 1)) begin
      phase_d = '0;
    end else begin
      phase_d = phase_base + PhW'(1);
    end
  end

  assign strb_o.tick = tick_i;
  assign strb_o.ms   = tick_i && (phase_q == '0);
  assign strb_o.scan = tick_i && scan;

  // Counters advance on ticks only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      phase_q <= '0;
    end else if (tick_i) begin
      tick_q  <= tick_d;
      phase_q <= phase_d;
    end
  end

endmodule

>>> src/tpek_pwm.sv
// PWM ramp and the three LED compare outputs.
module tpek_pwm import tpek_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic [LEVEL_W-1:0]  red_level_i,
  input  logic [LEVEL_W-1:0]  green_level_i,
  input  logic [LEVEL_W-1:0]  blue_level_i,
  output logic [NUM_LEDS-1:0] led_d_o
);

  logic [LEVEL_W-1:0]  ramp_q, ramp_d;
  logic [NUM_LEDS-1:0] led_q;

  // On a tick the ramp steps and each LED compares against the new ramp.
  always_comb begin
    ramp_d  = ramp_q + LEVEL_W'(1);
    led_d_o = led_q;
    if (tick_i) begin
      led_d_o = {blue_level_i > ramp_d, green_level_i > ramp_d, red_level_i > ramp_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q <= '0;
      led_q  <= '0;
    end else if (tick_i) begin
      ramp_q <= ramp_d;
      led_q  <= led_d_o;
    end
  end

endmodule

>>> src/tpek_dial_keys.sv
// Encoder dial count, countdown timers and sticky key press flags.
module tpek_dial_keys import tpek_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  req_t      req_i,
  input  strb_t     strb_i,
  output dk_state_t st_d_o
);

  logic signed [VALUE_W-1:0] dial_q, dial_d;
  logic signed [VALUE_W-1:0] timer_q [NUM_TIMERS];
  logic signed [VALUE_W-1:0] timer_d [NUM_TIMERS];
  logic [NUM_KEYS-1:0]       flags_q, flags_d;
  logic [NUM_KEYS-1:0]       keys_q, keys_d, key_now;
  logic                      enc_q, enc_d, enc_now;

  assign enc_now = !req_i.enc_phase_b;
  assign key_now = ~{req_i.key_dial_pin, req_i.key_two_pin, req_i.key_one_pin};

  // Next state for the request in flight.
  always_comb begin
    dial_d  = dial_q;
    flags_d = flags_q;
    keys_d  = keys_q;
    enc_d   = enc_q;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_d[i] = timer_q[i];
    end

    // Encoder edge moves the dial; timers above zero count down.
    if (strb_i.ms) begin
      if (enc_now != enc_q) begin
        if (enc_now == req_i.enc_phase_a) begin
          dial_d = dial_q + VALUE_W'(1);
        end else begin
          dial_d = dial_q - VALUE_W'(1);
        end
      end
      enc_d = enc_now;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (timer_q[i] > 0) begin
          timer_d[i] = timer_q[i] - VALUE_W'(1);
        end
      end
    end

    // Key scan sets a flag on each press edge.
    if (strb_i.scan) begin
      flags_d = flags_q | (key_now & ~keys_q);
      keys_d  = key_now;
    end

    // Software accesses.
    if (!strb_i.tick) begin
      case (req_i.command)
        CMD_LOAD_TIMER: begin
          if (req_i.timer_select < 2'(NUM_TIMERS)) begin
            timer_d[req_i.timer_select] = req_i.write_value;
          end
        end
        CMD_CLEAR_FLAGS: flags_d = flags_q & ~req_i.flag_clear_mask;
        CMD_SET_DIAL:    dial_d  = req_i.write_value;
        default: ;
      endcase
    end
  end

  assign st_d_o.dial   = dial_d;
  assign st_d_o.timer0 = timer_d[0];
  assign st_d_o.timer1 = timer_d[1];
  assign st_d_o.timer2 = timer_d[2];
  assign st_d_o.flags  = flags_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dial_q  <= '0;
      flags_q <= '0;
      keys_q  <= '0;
      enc_q   <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_q[i] <= '0;
      end
    end else if (en_i) begin
      dial_q  <= dial_d;
      flags_q <= flags_d;
      keys_q  <= keys_d;
      enc_q   <= enc_d;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_q[i] <= timer_d[i];
      end
    end
  end

endmodule

>>> src/tick_pwm_encoder_key_scanner_core.sv
// Flow: an accepted request is held in the request register and moves into the result
// register when the result register is free or emptying.
// Throughput: one request per cycle unless the output stalls; the state update of each
// request is combinational logic between the request and result registers.
// Reset: asynchronous, active low; clears the counters, ramp, LEDs, dial, timers,
// key history, flags and LED level registers. No clearing pass is needed.
module tick_pwm_encoder_key_scanner_core import tpek_pkg::*; #(
  parameter int unsigned TICKS_PER_MS   = 10,
  parameter int unsigned TICKS_PER_SCAN = 100
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output res_t               out_res_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [LEVEL_W-1:0] cfg_wdata_i
);

  logic [LEVEL_W-1:0]  red_q, green_q, blue_q;
  logic                in_vld_q, out_vld_q;
  req_t                in_req_q;
  res_t                out_res_q, res_d;
  logic                adv, tick;
  strb_t               strb;
  logic [NUM_LEDS-1:0] led_d;
  dk_state_t           dk_d;

  // The request register moves on whenever the result register is free or emptying.
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign tick       = adv && (in_req_q.command == CMD_TICK);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RED:   red_q   <= cfg_wdata_i;
        CFG_GREEN: green_q <= cfg_wdata_i;
        CFG_BLUE:  blue_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tpek_timebase #(
    .TICKS_PER_MS  (TICKS_PER_MS),
    .TICKS_PER_SCAN(TICKS_PER_SCAN)
  ) u_timebase (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tick_i(tick),
    .strb_o(strb)
  );

  tpek_pwm u_pwm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .red_level_i  (red_q),
    .green_level_i(green_q),
    .blue_level_i (blue_q),
    .led_d_o      (led_d)
  );

  tpek_dial_keys u_dial_keys (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .req_i (in_req_q),
    .strb_i(strb),
    .st_d_o(dk_d)
  );

  // Result assembled from the post-request state.
  always_comb begin
    res_d.led_red_on    = led_d[0];
    res_d.led_green_on  = led_d[1];
    res_d.led_blue_on   = led_d[2];
    res_d.dial_count    = dk_d.dial;
    res_d.timer_zero    = dk_d.timer0;
    res_d.timer_one     = dk_d.timer1;
    res_d.timer_two     = dk_d.timer2;
    res_d.key_one_flag  = dk_d.flags[0];
    res_d.key_two_flag  = dk_d.flags[1];
    res_d.key_dial_flag = dk_d.flags[2];
  end

  // Request register and result register valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= in_req_i;
    end
    if (adv) begin
      out_res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

endmodule

>>> src/tpek_checker.sv
// Port-level checker for the tick PWM encoder key scanner, bound to the top level.
`include "tick_pwm_encoder_key_scanner_core_defines.svh"

module tpek_checker import tpek_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input res_t out_res_o
);

  // A stalled result stays valid and unchanged.
  `TPEK_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_res_o))

  // The request side stalls only while a result is waiting and stalled.
  `TPEK_ASSERT_IMP(a_in_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A result leaves only after it was taken.
  `TPEK_ASSERT_IMP(a_out_drop, clk_i, rst_ni, $fell(out_valid_o), $past(!out_stall_i))

endmodule

bind tick_pwm_encoder_key_scanner_core tpek_checker u_tpek_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_res_o  (out_res_o)
);
